// ----- src/drd_pkg.sv -----
// Package: result record type and protocol constants for the datagram record demultiplexer.
`default_nettype none
package drd_pkg;

    localparam logic [7:0] CHANNEL_RECORD_ID = 8'd80;
    localparam logic [7:0] CHANNEL_RESET     = 8'd90;
    localparam logic [3:0] CHANNEL_REC_LEN   = 4'd10;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_PAD     = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;
    localparam logic [1:0] KIND_CHANNEL = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] robot;
        logic [7:0] byte_val;
        logic [7:0] pad;
        logic       first;
        logic       last;
    } t_result;

    typedef struct packed {
        logic v0;
        logic v1;
    } t_push;

endpackage
`default_nettype wire

// ----- src/drd_parser.sv -----
// Record parser: per-byte state machine that produces up to two results per byte.
`default_nettype none
module drd_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_datagram_last,
    output drd_pkg::t_push        o_push,
    output drd_pkg::t_result      o_res0,
    output drd_pkg::t_result      o_res1
);

    localparam logic [2:0] PH_ID        = 3'd0;
    localparam logic [2:0] PH_LEN       = 3'd1;
    localparam logic [2:0] PH_PAY_FIRST = 3'd2;
    localparam logic [2:0] PH_PAY_REST  = 3'd3;
    localparam logic [2:0] PH_CH_BODY   = 3'd4;
    localparam logic [2:0] PH_CH_SKIP   = 3'd5;

    logic [2:0] r_phase,   n_phase;
    logic [3:0] r_offset,  n_offset;
    logic [7:0] r_robot,   n_robot;
    logic [7:0] r_remain,  n_remain;
    logic [7:0] r_cand,    n_cand;
    logic [7:0] r_current, n_current;

    logic [7:0] rem_dec;
    logic [3:0] off_inc;

    always_comb begin
        rem_dec   = r_remain - 8'd1;
        off_inc   = r_offset + 4'd1;
        n_phase   = r_phase;
        n_offset  = r_offset;
        n_robot   = r_robot;
        n_remain  = r_remain;
        n_cand    = r_cand;
        n_current = r_current;
        o_push    = '{v0: 1'b0, v1: 1'b0};
        o_res0    = '0;
        o_res1    = '0;

        unique case (r_phase)
            PH_LEN: begin
                if (i_data_byte == 8'd0) begin
                    o_push.v0 = 1'b1;
                    o_res0    = '{kind: drd_pkg::KIND_EMPTY, robot: r_robot, byte_val: 8'd0,
                                  pad: 8'd0, first: 1'b1, last: 1'b1};
                    n_phase   = PH_ID;
                end else if (i_datagram_last) begin
                    o_push.v0 = 1'b1;
                    o_res0    = '{kind: drd_pkg::KIND_PAD, robot: r_robot, byte_val: 8'd0,
                                  pad: i_data_byte, first: 1'b1, last: 1'b1};
                end else begin
                    n_remain = i_data_byte;
                    n_phase  = PH_PAY_FIRST;
                end
            end
            PH_PAY_FIRST, PH_PAY_REST: begin
                n_remain  = rem_dec;
                o_push.v0 = 1'b1;
                o_res0    = '{kind: drd_pkg::KIND_PAYLOAD, robot: r_robot,
                              byte_val: i_data_byte, pad: 8'd0,
                              first: (r_phase == PH_PAY_FIRST), last: (rem_dec == 8'd0)};
                if (rem_dec == 8'd0) begin
                    n_phase = PH_ID;
                end else begin
                    n_phase = PH_PAY_REST;
                    if (i_datagram_last) begin
                        o_push.v1 = 1'b1;
                        o_res1    = '{kind: drd_pkg::KIND_PAD, robot: r_robot, byte_val: 8'd0,
                                      pad: rem_dec, first: 1'b0, last: 1'b1};
                    end
                end
            end
            PH_CH_BODY: begin
                if (r_offset == 4'd1) begin
                    n_cand = i_data_byte;
                end
                if (r_offset >= 4'd7) begin
                    if (i_data_byte == r_cand && r_cand != r_current) begin
                        n_current = r_cand;
                        o_push.v0 = 1'b1;
                        o_res0    = '{kind: drd_pkg::KIND_CHANNEL, robot: 8'd0,
                                      byte_val: r_cand, pad: 8'd0, first: 1'b0, last: 1'b0};
                    end
                    n_phase = PH_CH_SKIP;
                end
                n_offset = off_inc;
            end
            PH_CH_SKIP: begin
                n_offset = off_inc;
                if (off_inc >= drd_pkg::CHANNEL_REC_LEN) begin
                    n_phase  = PH_ID;
                    n_offset = 4'd0;
                end
            end
            default: begin
                if (i_data_byte == drd_pkg::CHANNEL_RECORD_ID) begin
                    n_phase  = PH_CH_BODY;
                    n_offset = 4'd1;
                end else begin
                    n_robot = i_data_byte;
                    n_phase = PH_LEN;
                end
            end
        endcase

        if (i_datagram_last) begin
            n_phase  = PH_ID;
            n_offset = 4'd0;
            n_remain = 8'd0;
        end

        if (!i_accept) begin
            o_push = '{v0: 1'b0, v1: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ID;
            r_offset  <= 4'd0;
            r_robot   <= 8'd0;
            r_remain  <= 8'd0;
            r_cand    <= 8'd0;
            r_current <= drd_pkg::CHANNEL_RESET;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_offset  <= n_offset;
            r_robot   <= n_robot;
            r_remain  <= n_remain;
            r_cand    <= n_cand;
            r_current <= n_current;
        end
    end

endmodule
`default_nettype wire

// ----- src/drd_result_queue.sv -----
// Result queue: four-entry register queue taking up to two results per cycle.
`default_nettype none
module drd_result_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire drd_pkg::t_push   i_push,
    input  wire drd_pkg::t_result i_res0,
    input  wire drd_pkg::t_result i_res1,
    input  wire logic             i_pop,
    output logic                  o_nonempty,
    output logic                  o_full2,
    output drd_pkg::t_result      o_head
);

    drd_pkg::t_result r_entry [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_count, n_count;
    logic [2:0] push_n;
    logic       pop_ok;
    logic [1:0] wp_next;

    assign o_nonempty = (r_count != 3'd0);
    assign o_full2    = (r_count > 3'd2);
    assign o_head     = r_entry[r_rp];
    assign pop_ok     = i_pop & o_nonempty;
    assign wp_next    = r_wp + 2'd1;

    always_comb begin
        push_n  = {2'b00, i_push.v0} + {2'b00, i_push.v1};
        n_wp    = r_wp + push_n[1:0];
        n_rp    = r_rp + {1'b0, pop_ok};
        n_count = r_count + push_n - {2'b00, pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_entry[r_wp] <= i_res0;
        end
        if (i_push.v1) begin
            r_entry[wp_next] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 2'd0;
            r_rp    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- src/datagram_record_demultiplexer_unit.sv -----
// Top level: datagram record demultiplexer, byte stream in, tagged results out.
//
//   Channel | Direction | Handshake                | Payload
//   in      | sink      | i_in_valid / o_in_stall  | i_data_byte, i_datagram_last
//   out     | source    | o_out_valid / i_out_stall| o_result_kind, o_dest_node, o_out_byte,
//           |           |                          | o_pad_count, o_record_first, o_record_last
//
// One byte per cycle unless the input is stalled; each byte is parsed in the cycle it is taken
// and its results are registered into a four-entry queue whose head drives the output.
// A byte yields at most two results; the second only on a cut-off payload.
// The input stalls while the queue holds more than two results.
// Synchronous active-low reset clears parser state and empties the queue.
`default_nettype none
module datagram_record_demultiplexer_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_datagram_last,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_result_kind,
    output logic [7:0]      o_dest_node,
    output logic [7:0]      o_out_byte,
    output logic [7:0]      o_pad_count,
    output logic            o_record_first,
    output logic            o_record_last
);

    logic             in_accept;
    logic             q_full2;
    drd_pkg::t_push   push;
    drd_pkg::t_result res0;
    drd_pkg::t_result res1;
    drd_pkg::t_result head;

    assign o_in_stall = q_full2;
    assign in_accept  = i_in_valid & ~q_full2;

    drd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_data_byte     (i_data_byte),
        .i_datagram_last (i_datagram_last),
        .o_push          (push),
        .o_res0          (res0),
        .o_res1          (res1)
    );

    drd_result_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_pop      (~i_out_stall),
        .o_nonempty (o_out_valid),
        .o_full2    (q_full2),
        .o_head     (head)
    );

    assign o_result_kind  = head.kind;
    assign o_dest_node    = head.robot;
    assign o_out_byte     = head.byte_val;
    assign o_pad_count    = head.pad;
    assign o_record_first = head.first;
    assign o_record_last  = head.last;

endmodule
`default_nettype wire

// ----- src/drd_checker.sv -----
// Checker: port-level assertions for the datagram record demultiplexer, with bind.
`default_nettype none
module drd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [1:0] o_result_kind,
    input wire logic [7:0] o_dest_node,
    input wire logic [7:0] o_out_byte,
    input wire logic [7:0] o_pad_count,
    input wire logic       o_record_first,
    input wire logic       o_record_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stalled after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_kind)
            && $stable(o_out_byte) && $stable(o_pad_count) && $stable(o_dest_node))
        else $error("stalled result changed");

    a_channel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == drd_pkg::KIND_CHANNEL |->
            o_dest_node == 8'd0 && o_pad_count == 8'd0 && !o_record_first && !o_record_last)
        else $error("channel result carries record fields");

    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == drd_pkg::KIND_EMPTY |->
            o_record_first && o_record_last && o_out_byte == 8'd0 && o_pad_count == 8'd0)
        else $error("empty payload result malformed");

    a_pad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == drd_pkg::KIND_PAD |->
            o_record_last && o_out_byte == 8'd0 && o_pad_count != 8'd0)
        else $error("pad result malformed");

endmodule

bind datagram_record_demultiplexer_unit drd_checker u_drd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_kind  (o_result_kind),
    .o_dest_node    (o_dest_node),
    .o_out_byte     (o_out_byte),
    .o_pad_count    (o_pad_count),
    .o_record_first (o_record_first),
    .o_record_last  (o_record_last)
);
`default_nettype wire
